### rtl/overwrite_ring_block_reader_assert.svh
// Assertion macros used by the ring reader sequencer (owrb_seq).
// OWRB_ASSERT_NOW: consequent must hold in the same cycle as the antecedent.
// OWRB_ASSERT_NEXT: consequent must hold one cycle after the antecedent.
`ifndef OVERWRITE_RING_BLOCK_READER_ASSERT_SVH
`define OVERWRITE_RING_BLOCK_READER_ASSERT_SVH

`ifndef SYNTH
`define OWRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owrb assertion failed");
`define OWRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owrb assertion failed");
`else
`define OWRB_ASSERT_NOW(label, ante, cons)
`define OWRB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/owrb_pkg.sv
package owrb_pkg;

  localparam int unsigned BUFFER_DEPTH = 262144;
  localparam int unsigned MAX_BLOCK    = 64;
  localparam int unsigned PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned IN_DATA_W    = 24;

  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUFFER_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_BLOCK);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_FAIL
  } owrb_state_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [PTR_W-1:0]    addr;
    logic [SAMPLE_W-1:0] wdata;
  } owrb_mem_req_t;

  typedef struct packed {
    logic load;
    logic ok;
    logic last;
  } owrb_emit_t;

endpackage

### rtl/owrb_ram.sv
module owrb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/owrb_seq.sv
module owrb_seq
  import owrb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [LEN_W-1:0]    in_len,
  input  logic                out_free,
  output logic                in_ready,
  output owrb_mem_req_t       mem_req,
  output owrb_emit_t          emit
);

  owrb_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;

  // shared pointer unit: increment with wrap
  logic [PTR_W-1:0] ptr_op;
  logic [PTR_W-1:0] ptr_inc;
  logic             bad_len;

  // a full ring has both pointers equal, so one increment serves both on push
  assign ptr_op  = (state_r == S_IDLE) ? wr_ptr_r : rd_ptr_r;
  assign ptr_inc = (ptr_op == PTR_LAST) ? '0 : ptr_op + 1'b1;

  assign bad_len = (in_len == '0) || (in_len > LEN_MAX) ||
                   (CNT_W'(in_len) > fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      rem_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    in_ready      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = rd_ptr_r;
    mem_req.wdata = in_sample;
    emit.load     = 1'b0;
    emit.ok       = 1'b0;
    emit.last     = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_PUSH) begin
            mem_req.we   = 1'b1;
            mem_req.addr = wr_ptr_r;
            wr_ptr_nxt   = ptr_inc;
            // drop the oldest sample when full
            if (fill_r == FULL_COUNT) begin
              rd_ptr_nxt = ptr_inc;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end else if (bad_len) begin
            state_nxt = S_FAIL;
          end else begin
            rem_nxt   = in_len;
            state_nxt = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        mem_req.re = 1'b1;
        state_nxt  = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          emit.load  = 1'b1;
          emit.ok    = 1'b1;
          emit.last  = (rem_r == LEN_W'(1));
          rd_ptr_nxt = ptr_inc;
          fill_nxt   = fill_r - 1'b1;
          rem_nxt    = rem_r - 1'b1;
          state_nxt  = (rem_r == LEN_W'(1)) ? S_IDLE : S_ADDR;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          emit.load = 1'b1;
          emit.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`include "overwrite_ring_block_reader_assert.svh"

  `OWRB_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FULL_COUNT)
  `OWRB_ASSERT_NOW(a_full_ptrs, fill_r == FULL_COUNT, rd_ptr_r == wr_ptr_r)
  `OWRB_ASSERT_NOW(a_emit_free, emit.load, out_free)
  `OWRB_ASSERT_NEXT(a_addr_data, state_r == S_ADDR, state_r == S_DATA)

endmodule

### rtl/overwrite_ring_block_reader.sv
// Overwriting ring of 262144 signed Q1.15 samples with block read.
// Input channel in_*: in_tuser selects the action (0 push, 1 block read);
// in_tdata carries the sample (pushes) and the block length (reads).
// Output channel out_*: one transfer per sample of a successful read, ok on
// out_tuser, out_tlast on the final sample. A read asking for zero, more
// than 64, or more samples than are held gives a single transfer with
// data 0, ok 0 and tlast 1, and leaves the ring untouched.
// Pushes give no output and leave in_tready high; a push into a full ring
// drops the oldest sample.
// A block read steps, per sample, through S_ADDR (registered RAM read) and
// S_DATA (load of the output register once it is free); the first sample
// reaches out_tvalid via the output register. A failing read passes through
// S_FAIL, which loads its error transfer into the output register.
// in_tready is low while a read is in progress; an output register holds a
// finished sample, and a stalled receiver halts the read sequencer on it.
// Reset clears the state, pointers, fill count and output valid; sample
// storage is not cleared, since only written entries are ever read.
module overwrite_ring_block_reader
  import owrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,  // [15:0] sample, [22:16] block_length
  input  logic                 in_tuser,  // [0] action
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata, // [15:0] read_sample
  output logic                 out_tuser, // [0] ok
  output logic                 out_tlast
);

  owrb_mem_req_t       mem_req;
  owrb_emit_t          emit;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic                out_free;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_ok_r;
  logic                out_last_r;

  assign out_free = !out_valid_r || out_tready;

  owrb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .in_len    (in_tdata[SAMPLE_W+LEN_W-1:SAMPLE_W]),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .mem_req   (mem_req),
    .emit      (emit)
  );

  owrb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.addr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_sample_r <= emit.ok ? mem_rdata : '0;
      out_ok_r     <= emit.ok;
      out_last_r   <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

endmodule
